// ===== design/brb_pkg.sv =====
package brb_pkg;

	localparam int STORE_DEPTH = 4096;
	localparam int MAX_BYTES   = 8;

	localparam int IDX_W  = $clog2(STORE_DEPTH);
	localparam int LVL_W  = 13;
	localparam int CNT_W  = 4;
	localparam int DATA_W = 64;
	localparam int POS_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_PULL  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [CNT_W-1:0]  byte_count;
		logic [DATA_W-1:0] push_data;
	} req_t;

	typedef struct packed {
		logic              status;
		logic [DATA_W-1:0] pull_data;
		logic [LVL_W-1:0]  free_level;
	} rsp_t;

endpackage

// ===== design/byte_ring_buffer.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  brb_pkg::req_t (opcode, byte_count, push_data)
// rsp      out        rsp_valid / rsp_stall  brb_pkg::rsp_t (status, pull_data, free_level)
// cfg      in         cfg_valid / cfg_ready  cfg_data, capacity in bytes
//
// One request at a time. A refused, clear or zero-byte request goes from idle
// straight to done; a push passes idle, run, done and a pull idle, run, wait,
// done: the byte store is one single-port RAM that moves one byte per cycle.
// Reset sets capacity and free level to the full store and both indices to zero.
// A result waits in the output register while the next request is taken; a
// stalled rsp holds the sequencer in its done state.
module byte_ring_buffer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  brb_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output brb_pkg::rsp_t             rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [brb_pkg::LVL_W-1:0] cfg_data
);

	logic          idle;
	logic          done;
	logic          load;
	logic          start;
	logic          rsp_valid_q;
	brb_pkg::rsp_t rsp_q;
	brb_pkg::rsp_t seq_rsp;

	assign cfg_ready = idle;
	assign req_stall = !idle || cfg_valid;
	assign start     = req_valid && !req_stall;
	assign load      = done && (!rsp_valid_q || !rsp_stall);

	brb_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.start   (start),
		.req     (req),
		.take    (load),
		.idle    (idle),
		.done    (done),
		.rsp     (seq_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= seq_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== design/brb_ram.sv =====
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== design/brb_seq.sv =====
module brb_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [brb_pkg::LVL_W-1:0]  cfg_data,
	input  logic                       start,
	input  brb_pkg::req_t              req,
	input  logic                       take,
	output logic                       idle,
	output logic                       done,
	output brb_pkg::rsp_t              rsp
);

	localparam int LW = brb_pkg::LVL_W;
	localparam int IW = brb_pkg::IDX_W;
	localparam int CW = brb_pkg::CNT_W;
	localparam int PW = brb_pkg::POS_W;
	localparam int DW = brb_pkg::DATA_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]    state_q;
	logic [1:0]    op_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] pos_s1;
	logic          rd_pend_s1;
	logic [DW-1:0] data_q;
	logic [DW-1:0] acc_q;
	logic [IW-1:0] rd_idx_q;
	logic [IW-1:0] wr_idx_q;
	logic [LW-1:0] free_q;
	logic [LW-1:0] cap_q;
	logic          status_q;

	logic [LW-1:0] cap_new;
	logic [LW-1:0] cnt_ext;
	logic          too_big;
	logic          push_ok;
	logic          pull_ok;
	logic          refused;
	logic          ram_we;
	logic [IW-1:0] ram_addr;
	logic [7:0]    ram_rdata;

	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
			input logic [LW-1:0] cap);
		logic [LW-1:0] inc;
		inc = LW'(idx) + LW'(1);
		return (inc >= cap) ? '0 : inc[IW-1:0];
	endfunction

	always_comb begin
		if (cfg_data == '0) begin
			cap_new = LW'(1);
		end else if (cfg_data > LW'(brb_pkg::STORE_DEPTH)) begin
			cap_new = LW'(brb_pkg::STORE_DEPTH);
		end else begin
			cap_new = cfg_data;
		end
	end

	assign cnt_ext = LW'(req.byte_count);
	assign too_big = req.byte_count > CW'(brb_pkg::MAX_BYTES);
	assign push_ok = !too_big && (cnt_ext <= free_q);
	assign pull_ok = !too_big && (cnt_ext <= (cap_q - free_q));

	always_comb begin
		case (req.opcode)
			brb_pkg::OP_PUSH:  refused = !push_ok;
			brb_pkg::OP_PULL:  refused = !pull_ok;
			brb_pkg::OP_CLEAR: refused = 1'b0;
			default:           refused = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rd_idx_q   <= '0;
			wr_idx_q   <= '0;
			free_q     <= LW'(brb_pkg::STORE_DEPTH);
			cap_q      <= LW'(brb_pkg::STORE_DEPTH);
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= (state_q == S_RUN) && (op_q == brb_pkg::OP_PULL);
			if (cfg_we) begin
				cap_q    <= cap_new;
				free_q   <= cap_new;
				rd_idx_q <= '0;
				wr_idx_q <= '0;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (start) begin
							state_q <= S_DONE;
							case (req.opcode)
								brb_pkg::OP_PUSH: begin
									if (push_ok) begin
										free_q <= free_q - cnt_ext;
										if (req.byte_count != '0) begin
											state_q <= S_RUN;
										end
									end
								end
								brb_pkg::OP_PULL: begin
									if (pull_ok) begin
										free_q <= free_q + cnt_ext;
										if (req.byte_count != '0) begin
											state_q <= S_RUN;
										end
									end
								end
								brb_pkg::OP_CLEAR: begin
									rd_idx_q <= '0;
									wr_idx_q <= '0;
									free_q   <= cap_q;
								end
								default: begin
								end
							endcase
						end
					end
					S_RUN: begin
						if (op_q == brb_pkg::OP_PUSH) begin
							wr_idx_q <= next_idx(wr_idx_q, cap_q);
						end else begin
							rd_idx_q <= next_idx(rd_idx_q, cap_q);
						end
						if (cnt_q == CW'(1)) begin
							state_q <= (op_q == brb_pkg::OP_PUSH) ? S_DONE : S_WAIT;
						end
					end
					S_WAIT: begin
						state_q <= S_DONE;
					end
					S_DONE: begin
						if (take) begin
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= pos_q;
		if (rd_pend_s1) begin
			acc_q[{pos_s1, 3'b000} +: 8] <= ram_rdata;
		end
		if (start) begin
			op_q     <= req.opcode;
			cnt_q    <= req.byte_count;
			data_q   <= req.push_data;
			acc_q    <= '0;
			pos_q    <= '0;
			status_q <= refused;
		end else if (state_q == S_RUN) begin
			cnt_q  <= cnt_q - CW'(1);
			pos_q  <= pos_q + PW'(1);
			data_q <= data_q >> 8;
		end
	end

	assign ram_we   = (state_q == S_RUN) && (op_q == brb_pkg::OP_PUSH);
	assign ram_addr = (op_q == brb_pkg::OP_PUSH) ? wr_idx_q : rd_idx_q;

	brb_ram #(
		.WIDTH(8),
		.DEPTH(brb_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(data_q[7:0]),
		.rdata(ram_rdata)
	);

	assign idle            = (state_q == S_IDLE);
	assign done            = (state_q == S_DONE);
	assign rsp.status      = status_q;
	assign rsp.pull_data   = acc_q;
	assign rsp.free_level  = free_q;

endmodule
